>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is low.
`define TSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold on a clock edge.
`define TSE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

>>> rtl/tse_pkg.sv
// Package for the topological sort engine: operation codes, field widths
// and the sequencer state type. Depends on nothing.
`default_nettype none
package tse_pkg;
    localparam int ID_W = 6;
    localparam int OP_W = 2;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_RESOLVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZERO,
        S_CNT_A,
        S_CNT_E,
        S_CNT_D,
        S_SEED_A,
        S_SEED_D,
        S_POP_A,
        S_POP_D,
        S_WALK_A,
        S_WALK_E,
        S_WALK_D,
        S_FINAL
    } state_t;
endpackage
`default_nettype wire

>>> rtl/topological_sort_engine.sv
// Top level of the topological sort engine: edge store, degree and queue
// memories and the resolve sequencer. Depends on tse_pkg.
`default_nettype none
// An item transfers when start is high and busy is low. Add-edge and clear
// do not raise busy and may follow one another every cycle. A resolve
// holds busy high while it zeroes the degree table, counts in-degrees
// over the stored edges, seeds the ready queue, then per emitted node
// walks the stored edges (updating the target's in-degree when the edge
// leaves that node), and closes the run. The edge and degree memories
// have registered reads, each accessed once per step. Each result is
// shown for one cycle with strobe high; the receiver cannot stall, so
// take every strobe. The last result of a run carries last, unresolved
// and edges_dropped, and shows in the same cycle that busy falls.
module topological_sort_engine #(
    parameter int NODES = 64,
    parameter int EDGES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tse_pkg::OP_W-1:0]   operation,
    input  logic [tse_pkg::ID_W-1:0]   from_node,
    input  logic [tse_pkg::ID_W-1:0]   to_node,
    output logic                       strobe,
    output logic [tse_pkg::ID_W-1:0]   node_id,
    output logic                       last,
    output logic                       empty_res,
    output logic                       unresolved,
    output logic                       edges_dropped
);
    import tse_pkg::*;

    localparam int NIW = $clog2(NODES);
    localparam int NCW = $clog2(NODES + 1);
    localparam int EIW = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int ECW = $clog2(EDGES + 1);

    // Memories: edge store (source, target), in-degree table, ready queue.
    logic [2*NIW-1:0] edge_mem [EDGES];
    logic [ECW-1:0]   deg_mem  [NODES];
    logic [NIW-1:0]   q_mem    [NODES];

    logic [2*NIW-1:0] edge_rdata_reg;
    logic [ECW-1:0]   deg_rdata_reg;
    logic [NIW-1:0]   q_rdata_reg;

    state_t           state_reg, state_next;
    logic [ECW-1:0]   total_reg, total_next;
    logic             ovf_reg, ovf_next;
    logic [NODES-1:0] present_reg, present_next;
    logic [ECW-1:0]   e_cnt_reg, e_cnt_next;
    logic [NIW-1:0]   n_cnt_reg, n_cnt_next;
    logic [NCW-1:0]   head_reg, head_next;
    logic [NCW-1:0]   tail_reg, tail_next;
    logic [NCW-1:0]   pres_cnt_reg, pres_cnt_next;
    logic [NIW-1:0]   hold_reg, hold_next;
    logic             hold_vld_reg, hold_vld_next;
    logic [NIW-1:0]   cur_reg, cur_next;
    logic [NIW-1:0]   tgt_reg, tgt_next;

    logic             strobe_reg, strobe_next;
    logic [ID_W-1:0]  node_id_reg, node_id_next;
    logic             last_reg, last_next;
    logic             empty_reg, empty_next;
    logic             unres_reg, unres_next;
    logic             drop_reg, drop_next;

    logic             accept;
    logic             ids_ok;
    logic             edge_we;
    logic             deg_we;
    logic [NIW-1:0]   deg_waddr;
    logic [ECW-1:0]   deg_wdata;
    logic [NIW-1:0]   deg_raddr;
    logic             q_we;
    logic [NIW-1:0]   q_wdata;
    logic [NIW-1:0]   rd_src;
    logic [NIW-1:0]   rd_tgt;
    logic             edge_done;
    logic             node_done;
    logic             q_room;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign ids_ok    = ({1'b0, from_node} < (ID_W+1)'(NODES))
                    && ({1'b0, to_node} < (ID_W+1)'(NODES));
    assign rd_src    = edge_rdata_reg[2*NIW-1:NIW];
    assign rd_tgt    = edge_rdata_reg[NIW-1:0];
    assign edge_done = (ECW'(e_cnt_reg + 1'b1) == total_reg);
    assign node_done = (n_cnt_reg == NIW'(NODES - 1));
    assign q_room    = (tail_reg < NCW'(NODES));

    // Edge store: written on add, read every cycle at the walk counter.
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[total_reg[EIW-1:0]] <= {from_node[NIW-1:0], to_node[NIW-1:0]};
        end
        edge_rdata_reg <= edge_mem[e_cnt_reg[EIW-1:0]];
    end

    // Degree table: one read and one write a cycle; the sequencer never uses
    // the data read from an entry in the cycle it is being written.
    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rdata_reg <= deg_mem[deg_raddr];
    end

    // Ready queue: push at tail, pop at head.
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[tail_reg[NIW-1:0]] <= q_wdata;
        end
        q_rdata_reg <= q_mem[head_reg[NIW-1:0]];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == OP_RESOLVE)
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (node_done)
                begin
                    state_next = (total_reg == '0) ? S_SEED_A : S_CNT_A;
                end
            end
            S_CNT_A:  state_next = S_CNT_E;
            S_CNT_E:  state_next = S_CNT_D;
            S_CNT_D:  state_next = edge_done ? S_SEED_A : S_CNT_A;
            S_SEED_A: state_next = S_SEED_D;
            S_SEED_D: state_next = node_done ? S_POP_A : S_SEED_A;
            S_POP_A:  state_next = (head_reg == tail_reg) ? S_FINAL : S_POP_D;
            S_POP_D:  state_next = (total_reg == '0) ? S_POP_A : S_WALK_A;
            S_WALK_A: state_next = S_WALK_E;
            S_WALK_E:
            begin
                if (rd_src == cur_reg)
                begin
                    state_next = S_WALK_D;
                end
                else
                begin
                    state_next = edge_done ? S_POP_A : S_WALK_A;
                end
            end
            S_WALK_D: state_next = edge_done ? S_POP_A : S_WALK_A;
            S_FINAL:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        present_next  = present_reg;
        e_cnt_next    = e_cnt_reg;
        n_cnt_next    = n_cnt_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        pres_cnt_next = pres_cnt_reg;
        hold_next     = hold_reg;
        hold_vld_next = hold_vld_reg;
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        strobe_next   = 1'b0;
        node_id_next  = '0;
        last_next     = 1'b0;
        empty_next    = 1'b0;
        unres_next    = 1'b0;
        drop_next     = 1'b0;
        edge_we       = 1'b0;
        deg_we        = 1'b0;
        deg_waddr     = n_cnt_reg;
        deg_wdata     = '0;
        deg_raddr     = n_cnt_reg;
        q_we          = 1'b0;
        q_wdata       = n_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_ADD:
                        begin
                            if (ids_ok)
                            begin
                                if (total_reg == ECW'(EDGES))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    edge_we    = 1'b1;
                                    total_next = ECW'(total_reg + 1'b1);
                                    present_next[from_node[NIW-1:0]] = 1'b1;
                                    present_next[to_node[NIW-1:0]]   = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            total_next   = '0;
                            ovf_next     = 1'b0;
                            present_next = '0;
                        end
                        OP_RESOLVE:
                        begin
                            n_cnt_next    = '0;
                            e_cnt_next    = '0;
                            head_next     = '0;
                            tail_next     = '0;
                            pres_cnt_next = '0;
                            hold_vld_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ZERO:
            begin
                deg_we     = 1'b1;
                n_cnt_next = node_done ? '0 : NIW'(n_cnt_reg + 1'b1);
            end
            S_CNT_E:
            begin
                deg_raddr = rd_tgt;
                tgt_next  = rd_tgt;
            end
            S_CNT_D:
            begin
                deg_we     = 1'b1;
                deg_waddr  = tgt_reg;
                deg_wdata  = ECW'(deg_rdata_reg + 1'b1);
                e_cnt_next = edge_done ? '0 : ECW'(e_cnt_reg + 1'b1);
            end
            S_SEED_D:
            begin
                if (present_reg[n_cnt_reg])
                begin
                    pres_cnt_next = NCW'(pres_cnt_reg + 1'b1);
                    if (deg_rdata_reg == '0 && q_room)
                    begin
                        q_we      = 1'b1;
                        tail_next = NCW'(tail_reg + 1'b1);
                    end
                end
                n_cnt_next = node_done ? '0 : NIW'(n_cnt_reg + 1'b1);
            end
            S_POP_A:
            begin
                if (head_reg != tail_reg)
                begin
                    head_next = NCW'(head_reg + 1'b1);
                end
            end
            S_POP_D:
            begin
                // Release the held node now that another follows it.
                strobe_next   = hold_vld_reg;
                node_id_next  = hold_vld_reg ? ID_W'(hold_reg) : '0;
                hold_next     = q_rdata_reg;
                hold_vld_next = 1'b1;
                cur_next      = q_rdata_reg;
                e_cnt_next    = '0;
            end
            S_WALK_E:
            begin
                deg_raddr = rd_tgt;
                tgt_next  = rd_tgt;
                if (rd_src != cur_reg)
                begin
                    e_cnt_next = edge_done ? '0 : ECW'(e_cnt_reg + 1'b1);
                end
            end
            S_WALK_D:
            begin
                q_wdata = tgt_reg;
                if (deg_rdata_reg != '0)
                begin
                    deg_we    = 1'b1;
                    deg_waddr = tgt_reg;
                    deg_wdata = ECW'(deg_rdata_reg - 1'b1);
                    if (deg_rdata_reg == ECW'(1) && q_room)
                    begin
                        q_we      = 1'b1;
                        tail_next = NCW'(tail_reg + 1'b1);
                    end
                end
                e_cnt_next = edge_done ? '0 : ECW'(e_cnt_reg + 1'b1);
            end
            S_FINAL:
            begin
                strobe_next  = 1'b1;
                node_id_next = hold_vld_reg ? ID_W'(hold_reg) : '0;
                last_next    = 1'b1;
                empty_next   = !hold_vld_reg;
                unres_next   = (tail_reg < pres_cnt_reg);
                drop_next    = ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            present_reg  <= '0;
            e_cnt_reg    <= '0;
            n_cnt_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            pres_cnt_reg <= '0;
            hold_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            node_id_reg  <= '0;
            last_reg     <= 1'b0;
            empty_reg    <= 1'b0;
            unres_reg    <= 1'b0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            ovf_reg      <= ovf_next;
            present_reg  <= present_next;
            e_cnt_reg    <= e_cnt_next;
            n_cnt_reg    <= n_cnt_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            pres_cnt_reg <= pres_cnt_next;
            hold_vld_reg <= hold_vld_next;
            strobe_reg   <= strobe_next;
            node_id_reg  <= node_id_next;
            last_reg     <= last_next;
            empty_reg    <= empty_next;
            unres_reg    <= unres_next;
            drop_reg     <= drop_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        cur_reg  <= cur_next;
        tgt_reg  <= tgt_next;
    end

    assign strobe        = strobe_reg;
    assign node_id       = node_id_reg;
    assign last          = last_reg;
    assign empty_res     = empty_reg;
    assign unresolved    = unres_reg;
    assign edges_dropped = drop_reg;
endmodule
`default_nettype wire

>>> rtl/tse_checker.sv
// Port-level checker for the topological sort engine, bound to the top level.
// Depends on tse_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tse_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [tse_pkg::OP_W-1:0] operation,
    input logic                     strobe,
    input logic                     last,
    input logic                     empty_res,
    input logic                     unresolved,
    input logic                     edges_dropped
);
    import tse_pkg::*;

    `TSE_ASSERT(a_mid_busy, (strobe && !last) |-> busy, "non-final result outside a run")
    `TSE_ASSERT(a_empty_last, empty_res |-> (strobe && last), "empty flag off the last result")
    `TSE_ASSERT(a_flags_last, (unresolved || edges_dropped) |-> (strobe && last), "flags off last")
    `TSE_ASSERT(a_resolve_busy, (start && !busy && operation == OP_RESOLVE) |=> busy, "no run")
    `TSE_NEVER(a_last_gap, strobe && last && $past(strobe && last), "two last results in a row")
endmodule

bind topological_sort_engine tse_checker u_tse_checker (.*);
`default_nettype wire
